>>> src/mas_pkg.sv
// Shared types, constants and helpers for the motion alarm controller.
// No dependencies; used by mas_core and motion_alarm_state_machine.
package mas_pkg;

    // Alarm modes as they appear in the result word.
    typedef enum logic [1:0] {
        MODE_IDLE      = 2'd0,
        MODE_WAITING   = 2'd1,
        MODE_VIGILANT  = 2'd2,
        MODE_TRIGGERED = 2'd3
    } mode_t;

    // Input request kinds carried on s_tuser.
    localparam logic REQ_FRAME = 1'b0;
    localparam logic REQ_RESET = 1'b1;

    // Configuration register indexes.
    localparam int unsigned CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] CFG_MOTION_THRESHOLD     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_STABLE_FRAMES_NEEDED = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_STABLE_WINDOW_US     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_PRE_DELAY_S          = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_POST_DELAY_S         = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_TRIGGER_S        = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_TRIGGER_S        = 3'd6;

    // Field widths.
    localparam int unsigned SEC_W   = 32;
    localparam int unsigned US_W    = 48;
    localparam int unsigned LEVEL_W = 24;
    localparam int unsigned TALLY_W = 8;
    localparam int unsigned DELAY_W = 16;
    localparam int unsigned CFG_DATA_W = 32;

    // Configuration register set.
    typedef struct packed {
        logic [LEVEL_W-1:0] motion_threshold;
        logic [TALLY_W-1:0] stable_frames_needed;
        logic [31:0]        stable_window_us;
        logic [DELAY_W-1:0] pre_delay_s;
        logic [DELAY_W-1:0] post_delay_s;
        logic [DELAY_W-1:0] min_trigger_s;
        logic [DELAY_W-1:0] max_trigger_s;
    } cfg_t;

    // Values after reset.
    localparam cfg_t CFG_RESET = '{
        motion_threshold:     24'd1000,
        stable_frames_needed: 8'd3,
        stable_window_us:     32'd1000000,
        pre_delay_s:          16'd5,
        post_delay_s:         16'd5,
        min_trigger_s:        16'd5,
        max_trigger_s:        16'd60
    };

    // One result word.
    typedef struct packed {
        logic [SEC_W-1:0]   segment_end;
        logic [TALLY_W-1:0] stable_count;
        mode_t              mode;
    } result_t;

    // Seconds plus a delay, held at all ones on overflow.
    function automatic logic [SEC_W-1:0] sat_add(input logic [SEC_W-1:0] a,
                                                 input logic [DELAY_W-1:0] b);
        logic [SEC_W:0] sum;
        sum = {1'b0, a} + {{(SEC_W+1-DELAY_W){1'b0}}, b};
        return sum[SEC_W] ? {SEC_W{1'b1}} : sum[SEC_W-1:0];
    endfunction

endpackage

>>> src/motion_alarm_state_machine.sv
// Motion alarm controller top level: stream ports, configuration registers,
// input and output registers. Depends on mas_pkg and mas_core.
//
// Usage: send one word per video frame on the s_ channel. s_tuser selects a
// frame evaluation (0) or a stream reset (1); s_tdata carries the seconds
// clock, the microsecond clock and the motion level. Each word yields exactly
// one result word on the m_ channel with the mode, the stable frame count and
// the current segment end second.
// A word is captured in the input register and evaluated there; its result is
// registered once the output register is free or being drained, and m_tvalid
// rises. Throughput: one word per cycle while m_tready stays high; the whole
// update of the alarm state is one pass of logic between the input register
// and the result register.
// Reset (aresetn low, synchronous) empties both registers, returns the alarm
// to idle with all time stamps cleared and loads the default configuration.
// When the receiver stalls, the result holds in the output register and the
// input register still takes one more word; s_tready drops after that.
// The user must write configuration via cfg_wr_en/cfg_addr/cfg_wr_data only
// while idle, which the block does not enforce; writes act on the next word.
module motion_alarm_state_machine (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [mas_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [mas_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [31:0] now_seconds, [79:32] now_micros, [103:80] motion_level
    input  logic [103:0]                      s_tdata,
    // [0] req_type
    input  logic [0:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [1:0] mode, [9:2] stable_count, [41:10] segment_end, [47:42] zero
    output logic [47:0]                       m_tdata
);

    mas_pkg::cfg_t                cfg_reg;
    logic                         in_valid_reg;
    logic                         req_reg;
    logic [mas_pkg::SEC_W-1:0]    sec_reg;
    logic [mas_pkg::US_W-1:0]     us_reg;
    logic [mas_pkg::LEVEL_W-1:0]  level_reg;
    logic                         out_valid_reg;
    mas_pkg::result_t             out_reg;
    mas_pkg::result_t             result;
    logic                         step;

    // A word is evaluated when the output register is free or being drained.
    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= mas_pkg::CFG_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                mas_pkg::CFG_MOTION_THRESHOLD:
                    cfg_reg.motion_threshold <= cfg_wr_data[mas_pkg::LEVEL_W-1:0];
                mas_pkg::CFG_STABLE_FRAMES_NEEDED:
                    cfg_reg.stable_frames_needed <= cfg_wr_data[mas_pkg::TALLY_W-1:0];
                mas_pkg::CFG_STABLE_WINDOW_US:
                    cfg_reg.stable_window_us <= cfg_wr_data;
                mas_pkg::CFG_PRE_DELAY_S:
                    cfg_reg.pre_delay_s <= cfg_wr_data[mas_pkg::DELAY_W-1:0];
                mas_pkg::CFG_POST_DELAY_S:
                    cfg_reg.post_delay_s <= cfg_wr_data[mas_pkg::DELAY_W-1:0];
                mas_pkg::CFG_MIN_TRIGGER_S:
                    cfg_reg.min_trigger_s <= cfg_wr_data[mas_pkg::DELAY_W-1:0];
                mas_pkg::CFG_MAX_TRIGGER_S:
                    cfg_reg.max_trigger_s <= cfg_wr_data[mas_pkg::DELAY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Input register payload.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            req_reg   <= s_tuser[0];
            sec_reg   <= s_tdata[31:0];
            us_reg    <= s_tdata[79:32];
            level_reg <= s_tdata[103:80];
        end
    end

    mas_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .req_type     (req_reg),
        .now_seconds  (sec_reg),
        .now_micros   (us_reg),
        .motion_level (level_reg),
        .cfg          (cfg_reg),
        .result       (result)
    );

    // Output register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge aclk) begin
        if (step) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_reg.segment_end, out_reg.stable_count, out_reg.mode};

endmodule

>>> src/mas_core.sv
// Alarm state registers and the combinational update for one frame word.
// Depends on mas_pkg for the mode type, configuration struct and sat_add.
module mas_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step,
    input  logic                        req_type,
    input  logic [mas_pkg::SEC_W-1:0]   now_seconds,
    input  logic [mas_pkg::US_W-1:0]    now_micros,
    input  logic [mas_pkg::LEVEL_W-1:0] motion_level,
    input  mas_pkg::cfg_t               cfg,
    output mas_pkg::result_t            result
);

    mas_pkg::mode_t               mode_reg, mode_next;
    logic [mas_pkg::TALLY_W-1:0]  tally_reg, tally_next;
    logic [mas_pkg::US_W-1:0]     wstart_reg, wstart_next;
    logic [mas_pkg::SEC_W-1:0]    arm_reg, arm_next;
    logic [mas_pkg::SEC_W-1:0]    tstart_reg, tstart_next;
    logic [mas_pkg::SEC_W-1:0]    segend_reg, segend_next;

    logic                         moving;
    logic [mas_pkg::US_W-1:0]     elapsed;
    logic                         in_window;
    logic [mas_pkg::TALLY_W-1:0]  tally_inc;
    logic                         fire_alarm;
    logic [mas_pkg::SEC_W-1:0]    lim_min;
    logic [mas_pkg::SEC_W-1:0]    lim_max;
    logic [mas_pkg::SEC_W-1:0]    seg_limit;
    logic                         arm_passed;
    logic                         seg_over;

    // Shared conditions of the frame evaluation.
    always_comb begin
        moving     = motion_level > cfg.motion_threshold;
        // A fresh window starts at this frame, so the elapsed time is zero.
        elapsed    = (tally_reg == '0) ? '0 : (now_micros - wstart_reg);
        in_window  = elapsed < {{(mas_pkg::US_W-32){1'b0}}, cfg.stable_window_us};
        tally_inc  = (tally_reg == {mas_pkg::TALLY_W{1'b1}}) ? tally_reg
                                                             : tally_reg + mas_pkg::TALLY_W'(1);
        fire_alarm = tally_inc >= cfg.stable_frames_needed;
        lim_min    = mas_pkg::sat_add(now_seconds, cfg.min_trigger_s);
        lim_max    = mas_pkg::sat_add(tstart_reg, cfg.max_trigger_s);
        arm_passed = now_seconds > arm_reg;
        seg_over   = now_seconds > segend_reg;
    end

    // Segment end for a new trigger uses this frame as its start.
    always_comb begin
        logic [mas_pkg::SEC_W-1:0] cap;
        cap = (mode_reg == mas_pkg::MODE_VIGILANT)
            ? mas_pkg::sat_add(now_seconds, cfg.max_trigger_s) : lim_max;
        seg_limit = (lim_min < cap) ? lim_min : cap;
    end

    // Next mode.
    always_comb begin
        mode_next = mode_reg;
        if (req_type == mas_pkg::REQ_RESET) begin
            mode_next = mas_pkg::MODE_IDLE;
        end else begin
            case (mode_reg)
                mas_pkg::MODE_IDLE: begin
                    mode_next = mas_pkg::MODE_WAITING;
                end
                mas_pkg::MODE_WAITING: begin
                    if (arm_passed) mode_next = mas_pkg::MODE_VIGILANT;
                end
                mas_pkg::MODE_VIGILANT: begin
                    if (moving && in_window && fire_alarm)
                        mode_next = mas_pkg::MODE_TRIGGERED;
                end
                mas_pkg::MODE_TRIGGERED: begin
                    if (seg_over) mode_next = mas_pkg::MODE_WAITING;
                end
                default: begin
                    mode_next = mas_pkg::MODE_IDLE;
                end
            endcase
        end
    end

    // Next values of the counters and time stamps.
    always_comb begin
        tally_next  = tally_reg;
        wstart_next = wstart_reg;
        arm_next    = arm_reg;
        tstart_next = tstart_reg;
        segend_next = segend_reg;
        if (req_type == mas_pkg::REQ_RESET) begin
            tally_next  = '0;
            wstart_next = '0;
            arm_next    = '0;
            tstart_next = '0;
            segend_next = '0;
        end else begin
            case (mode_reg)
                mas_pkg::MODE_IDLE: begin
                    arm_next = mas_pkg::sat_add(now_seconds, cfg.pre_delay_s);
                end
                mas_pkg::MODE_WAITING: begin
                end
                mas_pkg::MODE_VIGILANT: begin
                    if (moving) begin
                        if (tally_reg == '0) wstart_next = now_micros;
                        if (!in_window) begin
                            wstart_next = '0;
                            segend_next = '0;
                            tally_next  = '0;
                        end else if (fire_alarm) begin
                            tally_next  = '0;
                            wstart_next = '0;
                            tstart_next = now_seconds;
                            segend_next = seg_limit;
                        end else begin
                            tally_next  = tally_inc;
                        end
                    end
                end
                mas_pkg::MODE_TRIGGERED: begin
                    if (seg_over) begin
                        arm_next = mas_pkg::sat_add(now_seconds, cfg.post_delay_s);
                    end else if (moving) begin
                        segend_next = seg_limit;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Result word is the state after the step.
    always_comb begin
        result.mode         = mode_next;
        result.stable_count = tally_next;
        result.segment_end  = segend_next;
    end

    // State registers advance once per processed word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= mas_pkg::MODE_IDLE;
            tally_reg  <= '0;
            wstart_reg <= '0;
            arm_reg    <= '0;
            tstart_reg <= '0;
            segend_reg <= '0;
        end else if (step) begin
            mode_reg   <= mode_next;
            tally_reg  <= tally_next;
            wstart_reg <= wstart_next;
            arm_reg    <= arm_next;
            tstart_reg <= tstart_next;
            segend_reg <= segend_next;
        end
    end

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for motion_alarm_state_machine: directed and random frame words,
// each result word checked against an in-bench model of the alarm mode machine.
// Depends on mas_pkg and the RTL of the block; no files or arguments are read.
`timescale 1ns / 100ps

module tb_top;

    logic         aclk;
    logic         aresetn;
    logic         cfg_wr_en;
    logic [2:0]   cfg_addr;
    logic [31:0]  cfg_wr_data;
    logic         s_tvalid;
    logic         s_tready;
    // [31:0] now_seconds, [79:32] now_micros, [103:80] motion_level
    logic [103:0] s_tdata;
    // [0] req_type
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    // [1:0] mode, [9:2] stable_count, [41:10] segment_end, [47:42] zero
    logic [47:0]  m_tdata;

    motion_alarm_state_machine dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // Model copy of the alarm: configuration and state as the block should hold them.
    mas_pkg::cfg_t  alarm_cfg = mas_pkg::CFG_RESET;
    mas_pkg::mode_t alarm_mode = mas_pkg::MODE_IDLE;
    logic [7:0]     hit_tally = '0;
    logic [47:0]    win_start = '0;
    logic [31:0]    arm_s = '0;
    logic [31:0]    trig_start = '0;
    logic [31:0]    seg_end_s = '0;

    // Status words predicted for accepted frames, oldest first.
    mas_pkg::result_t expected_status[$];
    int               mismatches = 0;
    bit               gaps_on = 1'b1;
    bit               stalls_on = 1'b1;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Seconds plus a delay, held at all ones when the sum overflows.
    function automatic logic [31:0] clamp_sum(input logic [31:0] base,
                                              input logic [15:0] delta);
        logic [32:0] total;
        total = {1'b0, base} + {17'd0, delta};
        return total[32] ? 32'hFFFF_FFFF : total[31:0];
    endfunction

    // End of a segment: now plus the minimum, capped by start plus the maximum.
    function automatic logic [31:0] segment_bound(input logic [31:0] sec);
        logic [31:0] by_min;
        logic [31:0] by_max;
        by_min = clamp_sum(sec, alarm_cfg.min_trigger_s);
        by_max = clamp_sum(trig_start, alarm_cfg.max_trigger_s);
        return (by_min < by_max) ? by_min : by_max;
    endfunction

    // Advance the model by one accepted word and return the status it should produce.
    function automatic mas_pkg::result_t advance_alarm(input logic req,
                                                       input logic [31:0] sec,
                                                       input logic [47:0] us,
                                                       input logic [23:0] lvl);
        mas_pkg::result_t r;
        logic             moving;
        logic [47:0]      elapsed;
        moving = lvl > alarm_cfg.motion_threshold;
        if (req == mas_pkg::REQ_RESET) begin
            alarm_mode = mas_pkg::MODE_IDLE;
            hit_tally  = '0;
            win_start  = '0;
            arm_s      = '0;
            trig_start = '0;
            seg_end_s  = '0;
        end else begin
            case (alarm_mode)
                mas_pkg::MODE_IDLE: begin
                    arm_s = clamp_sum(sec, alarm_cfg.pre_delay_s);
                    alarm_mode = mas_pkg::MODE_WAITING;
                end
                mas_pkg::MODE_WAITING: begin
                    if (sec > arm_s)
                        alarm_mode = mas_pkg::MODE_VIGILANT;
                end
                mas_pkg::MODE_VIGILANT: begin
                    if (moving) begin
                        if (hit_tally == 8'd0)
                            win_start = us;
                        elapsed = us - win_start;
                        if (elapsed < {16'd0, alarm_cfg.stable_window_us}) begin
                            if (hit_tally != 8'hFF)
                                hit_tally = hit_tally + 8'd1;
                            if (hit_tally >= alarm_cfg.stable_frames_needed) begin
                                hit_tally  = '0;
                                win_start  = '0;
                                trig_start = sec;
                                seg_end_s  = segment_bound(sec);
                                alarm_mode = mas_pkg::MODE_TRIGGERED;
                            end
                        end else begin
                            // The window ran out: start counting afresh.
                            win_start = '0;
                            seg_end_s = '0;
                            hit_tally = '0;
                        end
                    end
                end
                default: begin
                    if (sec > seg_end_s) begin
                        arm_s = clamp_sum(sec, alarm_cfg.post_delay_s);
                        alarm_mode = mas_pkg::MODE_WAITING;
                    end else if (moving) begin
                        seg_end_s = segment_bound(sec);
                    end
                end
            endcase
        end
        r.mode         = alarm_mode;
        r.stable_count = hit_tally;
        r.segment_end  = seg_end_s;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [47:0] want,
                                 input logic [47:0] got);
        mismatches++;
        if (mismatches <= 40)
            $display("tb_top: %s mismatch at %0t: expected %0h, got %0h",
                     what, $realtime, want, got);
    endtask

    // Compare one result word with the oldest prediction.
    task automatic check_status_word(input logic [47:0] data);
        mas_pkg::result_t want;
        mas_pkg::result_t got;
        if (expected_status.size() == 0) begin
            flag_mismatch("unexpected word", 48'd0, data);
        end else begin
            want = expected_status.pop_front();
            got  = mas_pkg::result_t'(data[41:0]);
            if (got.mode !== want.mode)
                flag_mismatch("mode", want.mode, got.mode);
            if (got.stable_count !== want.stable_count)
                flag_mismatch("stable_count", want.stable_count, got.stable_count);
            if (got.segment_end !== want.segment_end)
                flag_mismatch("segment_end", want.segment_end, got.segment_end);
            if (data[47:42] !== 6'd0)
                flag_mismatch("padding", 48'd0, data[47:42]);
        end
    endtask

    // Outputs are stable at the falling edge; a word seen here is taken at the next rise.
    always @(negedge aclk) begin
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
            check_status_word(m_tdata);
    end

    // Result side: a random stall before each word, or none in steady stretches.
    initial begin : result_sink
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = stalls_on ? $urandom_range(0, 4) : 0;
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(negedge aclk);
            while (m_tvalid !== 1'b1) @(negedge aclk);
            @(posedge aclk);
        end
    end

    // Send one word after a random gap and predict its status once it is taken.
    task automatic send_word(input logic req, input logic [31:0] sec,
                             input logic [47:0] us, input logic [23:0] lvl);
        int gap;
        gap = gaps_on ? $urandom_range(0, 4) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {lvl, us, sec};
        s_tuser  <= req;
        @(negedge aclk);
        while (s_tready !== 1'b1) @(negedge aclk);
        @(posedge aclk);
        expected_status.push_back(advance_alarm(req, sec, us, lvl));
    endtask

    task automatic send_stream_reset();
        send_word(mas_pkg::REQ_RESET, $urandom, {16'($urandom), 32'($urandom)},
                  24'($urandom));
    endtask

    // Stop sending and hold until every predicted word has come back.
    task automatic settle_pipeline();
        s_tvalid <= 1'b0;
        while (expected_status.size() != 0) @(posedge aclk);
    endtask

    task automatic put_reg(input logic [2:0] addr, input logic [31:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= addr;
        cfg_wr_data <= data;
        @(posedge aclk);
    endtask

    // Write all seven registers; unused upper data bits carry noise.
    task automatic load_config(input mas_pkg::cfg_t c);
        put_reg(mas_pkg::CFG_MOTION_THRESHOLD,     {8'($urandom), c.motion_threshold});
        put_reg(mas_pkg::CFG_STABLE_FRAMES_NEEDED, {24'($urandom), c.stable_frames_needed});
        put_reg(mas_pkg::CFG_STABLE_WINDOW_US,     c.stable_window_us);
        put_reg(mas_pkg::CFG_PRE_DELAY_S,          {16'($urandom), c.pre_delay_s});
        put_reg(mas_pkg::CFG_POST_DELAY_S,         {16'($urandom), c.post_delay_s});
        put_reg(mas_pkg::CFG_MIN_TRIGGER_S,        {16'($urandom), c.min_trigger_s});
        put_reg(mas_pkg::CFG_MAX_TRIGGER_S,        {16'($urandom), c.max_trigger_s});
        cfg_wr_en <= 1'b0;
        alarm_cfg = c;
    endtask

    // Default settings: arming, level at threshold, window expiry, trigger,
    // extension, end of segment and saturation of the arm time.
    task automatic test_default_walkthrough();
        send_word(mas_pkg::REQ_FRAME, 32'd100, 48'd0, 24'd0);
        send_word(mas_pkg::REQ_FRAME, 32'd105, 48'd1_000_000, 24'd5000);
        send_word(mas_pkg::REQ_FRAME, 32'd106, 48'd2_000_000, 24'd1000);
        send_word(mas_pkg::REQ_FRAME, 32'd106, 48'd2_100_000, 24'd1000);
        send_word(mas_pkg::REQ_FRAME, 32'd107, 48'd3_000_000, 24'd1001);
        send_word(mas_pkg::REQ_FRAME, 32'd107, 48'd3_500_000, 24'hFF_FFFF);
        send_word(mas_pkg::REQ_FRAME, 32'd108, 48'd4_000_000, 24'd2000);
        send_word(mas_pkg::REQ_FRAME, 32'd108, 48'd4_100_000, 24'd2000);
        send_word(mas_pkg::REQ_FRAME, 32'd108, 48'd4_200_000, 24'd2000);
        send_word(mas_pkg::REQ_FRAME, 32'd109, 48'd4_300_000, 24'd2000);
        send_word(mas_pkg::REQ_FRAME, 32'd112, 48'd4_400_000, 24'd5000);
        send_word(mas_pkg::REQ_FRAME, 32'd118, 48'd5_000_000, 24'd0);
        send_word(mas_pkg::REQ_FRAME, 32'd124, 48'd6_000_000, 24'd0);
        send_stream_reset();
        send_word(mas_pkg::REQ_FRAME, 32'hFFFF_FFFE, 48'hFFFF_FFFF_FFFF, 24'hFF_FFFF);
        send_word(mas_pkg::REQ_FRAME, 32'hFFFF_FFFF, 48'd0, 24'd0);
        send_stream_reset();
    endtask

    // Zero delays and a full window: a trigger across the wrap of the microsecond clock.
    task automatic test_wrap_and_zero_delays();
        mas_pkg::cfg_t c;
        c = '{motion_threshold: 24'd0, stable_frames_needed: 8'd2,
              stable_window_us: 32'hFFFF_FFFF, pre_delay_s: 16'd0, post_delay_s: 16'd0,
              min_trigger_s: 16'd0, max_trigger_s: 16'd0};
        settle_pipeline();
        load_config(c);
        send_word(mas_pkg::REQ_FRAME, 32'd0, 48'hFFFF_FFFF_FFF0, 24'd0);
        send_word(mas_pkg::REQ_FRAME, 32'd1, 48'hFFFF_FFFF_FFF4, 24'd0);
        send_word(mas_pkg::REQ_FRAME, 32'd1, 48'hFFFF_FFFF_FFF8, 24'd1);
        send_word(mas_pkg::REQ_FRAME, 32'd1, 48'h0000_0000_0010, 24'd1);
        send_word(mas_pkg::REQ_FRAME, 32'd2, 48'h0000_0000_0020, 24'd0);
    endtask

    // No frames needed: the first vigilant frame over the threshold triggers at once.
    task automatic test_zero_frames_needed();
        mas_pkg::cfg_t c;
        c = '{motion_threshold: 24'd0, stable_frames_needed: 8'd0,
              stable_window_us: 32'd1000, pre_delay_s: 16'd0, post_delay_s: 16'd0,
              min_trigger_s: 16'd3, max_trigger_s: 16'd2};
        settle_pipeline();
        load_config(c);
        send_word(mas_pkg::REQ_FRAME, 32'd3, 48'h30, 24'd1);
        send_word(mas_pkg::REQ_FRAME, 32'd3, 48'h40, 24'd7);
    endtask

    // One phase of random traffic: mostly frames on a rising timeline, some noise
    // and stream resets. The first two phases use the register extremes.
    task automatic test_random_traffic(input int phase);
        mas_pkg::cfg_t c;
        logic [31:0]   sec;
        logic [47:0]   us;
        logic [23:0]   lvl;
        int unsigned   span;
        int            pick;
        settle_pipeline();
        case (phase)
            0: c = '1;
            1: c = '0;
            default: begin
                c.motion_threshold     = (phase == 5) ? 24'($urandom)
                                                      : 24'($urandom_range(0, 3000));
                c.stable_frames_needed = 8'($urandom_range(0, 5));
                c.stable_window_us     = $urandom_range(1000, 5_000_000);
                c.pre_delay_s          = 16'($urandom_range(0, 3));
                c.post_delay_s         = 16'($urandom_range(0, 3));
                c.min_trigger_s        = 16'($urandom_range(0, 6));
                c.max_trigger_s        = 16'($urandom_range(0, 12));
            end
        endcase
        load_config(c);
        gaps_on   = (phase % 3) != 1;
        stalls_on = (phase % 4) != 2;
        span = c.stable_window_us / 2;

        // Start the timeline near zero, near the top, or anywhere.
        case ($urandom_range(0, 2))
            0: sec = $urandom_range(0, 100);
            1: sec = 32'hFFFF_FFFF - $urandom_range(0, 40);
            default: sec = $urandom;
        endcase
        case ($urandom_range(0, 2))
            0: us = 48'($urandom_range(0, 1000));
            1: us = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 3_000_000));
            default: us = {16'($urandom), 32'($urandom)};
        endcase

        if ($urandom_range(0, 1) == 1)
            send_stream_reset();
        for (int n = 0; n < 150; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                send_stream_reset();
            end else if (pick < 7) begin
                send_word(mas_pkg::REQ_FRAME, $urandom, {16'($urandom), 32'($urandom)},
                          24'($urandom));
            end else begin
                if ($urandom_range(0, 2) == 0)
                    sec = sec + 32'($urandom_range(1, 2));
                if ($urandom_range(0, 9) == 0)
                    us = us + {16'd0, c.stable_window_us} + 48'd1;
                else
                    us = us + 48'($urandom_range(0, span));
                if ($urandom_range(0, 99) < 55 && c.motion_threshold != 24'hFF_FFFF)
                    lvl = 24'($urandom_range(32'(c.motion_threshold) + 1, 32'hFF_FFFF));
                else
                    lvl = 24'($urandom_range(0, 32'(c.motion_threshold)));
                send_word(mas_pkg::REQ_FRAME, sec, us, lvl);
            end
            // Let the pipeline run dry now and then.
            if (n % 50 == 49)
                settle_pipeline();
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = '0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_default_walkthrough();
        test_wrap_and_zero_delays();
        test_zero_frames_needed();
        for (int p = 0; p < 12; p++)
            test_random_traffic(p);

        settle_pipeline();
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #1_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

>>> filelist.f
src/mas_pkg.sv
src/mas_core.sv
src/motion_alarm_state_machine.sv
sim/tb_top.sv
